// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dxt1_pkg.sv =====
// ----------------------------------------------------------------------------
// dxt1_pkg
// shared types, constants and palette arithmetic of the block decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dxt1_pkg;

  localparam int unsigned MaxImageSize = 4096;
  localparam int unsigned SizeW        = 13;
  localparam int unsigned CtrW         = 10;
  localparam int unsigned BprW         = CtrW + 1;
  localparam int unsigned CoordW       = 12;
  localparam int unsigned QDepth       = 2;
  localparam int unsigned QPtrW        = $clog2(QDepth);
  localparam int unsigned QCntW        = $clog2(QDepth + 1);
  localparam int unsigned PixPerBlk    = 16;
  localparam int unsigned PixW         = $clog2(PixPerBlk);
  localparam int unsigned AddrW        = 3;

  localparam logic [15:0] MaskRed   = 16'hF800;
  localparam logic [15:0] MaskGreen = 16'h07E0;
  localparam logic [15:0] MaskBlue  = 16'h001F;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    CODE_C0  = 2'd0,
    CODE_C1  = 2'd1,
    CODE_MIX = 2'd2,
    CODE_ALT = 2'd3
  } code_e;

  typedef struct packed {
    logic [15:0] endpoint_color0;
    logic [15:0] endpoint_color1;
    logic [31:0] index_bits;
  } dxt1_blk_t;

  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic              inside_image;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              last_pixel;
  } dxt1_pix_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    rgb_t [3:0]      pal;
    logic [31:0]     idx;
    logic [CtrW-1:0] col;
    logic [CtrW-1:0] row;
  } dxt1_entry_t;

  typedef struct packed {
    logic [SizeW-1:0] width;
    logic [SizeW-1:0] height;
    logic [BprW-1:0]  blk_cols;
    logic [BprW-1:0]  blk_rows;
  } dxt1_geom_t;

  // exact floor(x / 3) for x below 768
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] prod;
    prod = 21'(x) * 21'd683;
    return prod[18:11];
  endfunction

  function automatic rgb_t expand565(input logic [15:0] c);
    rgb_t v;
    logic [15:0] rm, gm, bm;
    rm  = c & MaskRed;
    gm  = c & MaskGreen;
    bm  = c & MaskBlue;
    v.r = {rm[15:11], 3'b000};
    v.g = {gm[10:5], 2'b00};
    v.b = {bm[4:0], 3'b000};
    return v;
  endfunction

  function automatic logic [7:0] mix3(input logic [7:0] a, input logic [7:0] b);
    return div3(10'({a, 1'b0}) + 10'(b));
  endfunction

  function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = 9'(a) + 9'(b);
    return s[8:1];
  endfunction

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v);
    if (v == '0) begin
      return SizeW'(1);
    end else if (v > SizeW'(MaxImageSize)) begin
      return SizeW'(MaxImageSize);
    end
    return v;
  endfunction

endpackage

// ===== rtl/dxt1_block_decoder_core.sv =====
// ----------------------------------------------------------------------------
// dxt1_block_decoder_core
// DXT1 block decoder: one 8-byte block in, sixteen RGB888 pixels out
// ----------------------------------------------------------------------------
// Each accepted block yields sixteen pixel requests in raster order, one per
// clock from the back end's output register while out_stall_i is low; when
// idle, an accepted block is written into the queue and its first pixel is
// then registered in the output register. The front end decodes the palette
// on acceptance; a two-entry queue holds the block being drained plus one
// more, so the input stalls while a second waits. The user must write width
// and height (APB, byte address 0 and 4) only while idle; the core does not check.
`timescale 1ns / 1ps

module dxt1_block_decoder_core import dxt1_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  dxt1_blk_t        in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dxt1_pix_t        out_data_o
);

  logic [SizeW-1:0] width_q, height_q;
  logic [SizeW-1:0] w_clamp, h_clamp;
  logic [SizeW:0]   w_round, h_round;
  dxt1_geom_t       geom;
  reg_idx_e         sel;
  logic             q_full, q_push, q_pop, q_empty;
  dxt1_entry_t      q_wdata, q_head;

  assign pready = 1'b1;
  assign sel    = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SizeW'(4);
      height_q <= SizeW'(4);
    end else if (psel && penable && pwrite && pready) begin
      case (sel)
        REG_IMAGE_WIDTH:  width_q  <= pwdata[SizeW-1:0];
        REG_IMAGE_HEIGHT: height_q <= pwdata[SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_IMAGE_WIDTH:  prdata = 32'(width_q);
      REG_IMAGE_HEIGHT: prdata = 32'(height_q);
      default:          prdata = '0;
    endcase
  end

  assign w_clamp = clamp_size(width_q);
  assign h_clamp = clamp_size(height_q);
  assign w_round = (SizeW+1)'(w_clamp) + (SizeW+1)'(3);
  assign h_round = (SizeW+1)'(h_clamp) + (SizeW+1)'(3);

  always_comb begin
    geom.width    = w_clamp;
    geom.height   = h_clamp;
    geom.blk_cols = w_round[BprW+1:2];
    geom.blk_rows = h_round[BprW+1:2];
  end

  dxt1_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .geom_i     (geom),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  dxt1_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  dxt1_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .geom_i      (geom),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/dxt1_front.sv =====
// ----------------------------------------------------------------------------
// dxt1_front
// accepts blocks, builds the four-color palette and walks the block counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dxt1_front import dxt1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  dxt1_blk_t   in_data_i,
  input  dxt1_geom_t  geom_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output dxt1_entry_t q_data_o
);

  logic [CtrW-1:0] col_q, col_d;
  logic [CtrW-1:0] row_q, row_d;
  rgb_t            c0, c1;
  logic [BprW-1:0] col_inc, row_inc;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign c0 = expand565(in_data_i.endpoint_color0);
  assign c1 = expand565(in_data_i.endpoint_color1);

  always_comb begin
    q_data_o.pal[CODE_C0] = c0;
    q_data_o.pal[CODE_C1] = c1;
    if (in_data_i.endpoint_color0 > in_data_i.endpoint_color1) begin
      q_data_o.pal[CODE_MIX] = '{r: mix3(c0.r, c1.r), g: mix3(c0.g, c1.g),
                                 b: mix3(c0.b, c1.b)};
      q_data_o.pal[CODE_ALT] = '{r: mix3(c1.r, c0.r), g: mix3(c1.g, c0.g),
                                 b: mix3(c1.b, c0.b)};
    end else begin
      q_data_o.pal[CODE_MIX] = '{r: avg2(c0.r, c1.r), g: avg2(c0.g, c1.g),
                                 b: avg2(c0.b, c1.b)};
      q_data_o.pal[CODE_ALT] = '0;
    end
    q_data_o.idx = in_data_i.index_bits;
    q_data_o.col = col_q;
    q_data_o.row = row_q;
  end

  assign col_inc = BprW'(col_q) + BprW'(1);
  assign row_inc = BprW'(row_q) + BprW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (q_push_o) begin
      if (col_inc >= geom_i.blk_cols || col_inc[CtrW]) begin
        col_d = '0;
        if (row_inc >= geom_i.blk_rows || row_inc[CtrW]) begin
          row_d = '0;
        end else begin
          row_d = row_inc[CtrW-1:0];
        end
      end else begin
        col_d = col_inc[CtrW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== rtl/dxt1_queue.sv =====
// ----------------------------------------------------------------------------
// dxt1_queue
// short fifo of decoded block entries between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dxt1_queue import dxt1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  dxt1_entry_t push_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        empty_o,
  output dxt1_entry_t head_o
);

  dxt1_entry_t      mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPtrW'(QDepth - 1)) ? '0 : wptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPtrW'(QDepth - 1)) ? '0 : rptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, cnt_q <= QCntW'(QDepth), "queue count beyond depth")
  `ASSERT_IMPLIES(a_no_pop_empty, pop_i, !empty_o, "pop from empty queue")
  `ASSERT_IMPLIES(a_no_push_full, push_i, !full_o, "push into full queue")

endmodule

// ===== rtl/dxt1_back.sv =====
// ----------------------------------------------------------------------------
// dxt1_back
// emits the sixteen pixels of each queued block through an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dxt1_back import dxt1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  dxt1_entry_t q_head_i,
  output logic        q_pop_o,
  input  dxt1_geom_t  geom_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output dxt1_pix_t   out_data_o
);

  logic [PixW-1:0]   pix_q, pix_d;
  logic              vld_q, vld_d;
  dxt1_pix_t         out_q, pix_val;
  logic              load;
  logic [1:0]        code;
  logic [CoordW-1:0] x, y;
  rgb_t              color;

  assign load = !vld_q || !out_stall_i;

  assign code  = q_head_i.idx[{pix_q, 1'b0} +: 2];
  assign color = q_head_i.pal[code];
  assign x     = {q_head_i.col, pix_q[1:0]};
  assign y     = {q_head_i.row, pix_q[3:2]};

  always_comb begin
    pix_val.pixel_x      = x;
    pix_val.pixel_y      = y;
    pix_val.inside_image = (SizeW'(x) < geom_i.width) && (SizeW'(y) < geom_i.height);
    pix_val.red          = color.r;
    pix_val.green        = color.g;
    pix_val.blue         = color.b;
    pix_val.last_pixel   = (pix_q == PixW'(PixPerBlk - 1));
  end

  assign q_pop_o = load && !q_empty_i && pix_val.last_pixel;

  always_comb begin
    pix_d = pix_q;
    vld_d = vld_q;
    if (load) begin
      vld_d = !q_empty_i;
      if (!q_empty_i) begin
        pix_d = pix_q + PixW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !q_empty_i) begin
      out_q <= pix_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
      vld_q <= 1'b0;
    end else begin
      pix_q <= pix_d;
      vld_q <= vld_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPLIES(a_mid_block_has_entry, pix_q != '0, !q_empty_i,
                  "block in progress without queued entry")

endmodule
